// File: rtl/core/tpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tpc_pkg
// shared constants and codes of the triangle pixel coverage and depth test
// ============================================================================
package tpc_pkg;

    localparam int SCREEN_WIDTH_DEF  = 512;
    localparam int SCREEN_HEIGHT_DEF = 512;

    // command codes carried in the input tuser
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_SHADE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam int DEPTH_W = 16;
    localparam logic [DEPTH_W-1:0] DEPTH_FAR = 16'hFFFF;

    localparam int PIX_IDX_W = 18;
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = 17;
    localparam int EDGE_W    = 35;
    localparam int SAMP_W    = 36;
    localparam int AREA_W    = 37;
    localparam int NUM_W     = 56;
    localparam int DEN_W     = 38;

endpackage
`default_nettype wire

// File: rtl/core/tpc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tpc_ram
// generic simple dual port ram, one write port, one registered read port
// ============================================================================
module tpc_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/triangle_pixel_coverage_depth_test_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// triangle_pixel_coverage_depth_test_top
// 2x2 supersampled triangle coverage with a per-pixel depth buffer
// ============================================================================
// usage
//  - slave stream (i_s_*) takes commands: tuser holds the command, tdata the
//    corner slot, corner x/y/z, corner colour and the pixel x/y
//  - load and clear requests are absorbed in the cycle they are accepted
//  - a shade request produces exactly one result on the master stream (o_m_*)
//  - shade path: with no sample covered or the pixel off screen a request
//    goes straight to the result stage; a depth quotient that is negative or
//    saturates skips the divider; the bit-per-cycle depth divider sets the worst case
//  - one request is worked on at a time; the next shade is taken once the
//    previous result is in the output register, load/clear every cycle while idle
//  - depth read-modify-write goes through one ram: read in the coverage step,
//    write back after the depth compare, so no two accesses overlap
//  - reset: after i_rst_n is released the ram is swept to farthest depth,
//    one entry per cycle, SCREEN_WIDTH*SCREEN_HEIGHT entries (262144 at
//    default); o_s_tready stays low during the sweep
//  - receiver stall: a result waits in the output register; the block still
//    takes a new request and holds its result stage until the slot frees
// ============================================================================
module triangle_pixel_coverage_depth_test_top #(
    parameter int SCREEN_WIDTH  = tpc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tpc_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // vertex_slot[1:0] vert_x[17:2] vert_y[33:18] vert_z[49:34]
    // vert_color[73:50] pix_x[82:74] pix_y[91:83], zero above
    input  wire logic [95:0] i_s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // written[0] pixel_index[18:1] coverage[21:19] frag_depth[37:22]
    // red[45:38] green[53:46] blue[61:54], zero above
    output logic      [63:0] o_m_tdata
);

    localparam int NPIX = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW   = $clog2(NPIX);
    localparam logic [AW-1:0] HM1   = AW'(SCREEN_HEIGHT - 1);
    localparam logic [AW-1:0] WCONST = AW'(SCREEN_WIDTH);
    localparam logic [AW-1:0] LAST  = AW'(NPIX - 1);

    localparam int DW = tpc_pkg::DEPTH_W;
    localparam int XW = tpc_pkg::COORD_W;
    localparam int FW = tpc_pkg::DIFF_W;
    localparam int EW = tpc_pkg::EDGE_W;
    localparam int SW = tpc_pkg::SAMP_W;
    localparam int RW = tpc_pkg::AREA_W;
    localparam int NW = tpc_pkg::NUM_W;
    localparam int QW = tpc_pkg::DEN_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EDGE, S_COV, S_MUL, S_PREP, S_DCHK, S_DIV, S_DEPTH, S_OUT
    } t_state;

    t_state r_state;

    // input fields
    logic [1:0]  in_cmd, in_slot;
    logic [15:0] in_x, in_y, in_z;
    logic [23:0] in_color;
    logic [8:0]  in_px, in_py;
    assign in_cmd   = i_s_tuser;
    assign in_slot  = i_s_tdata[1:0];
    assign in_x     = i_s_tdata[17:2];
    assign in_y     = i_s_tdata[33:18];
    assign in_z     = i_s_tdata[49:34];
    assign in_color = i_s_tdata[73:50];
    assign in_px    = i_s_tdata[82:74];
    assign in_py    = i_s_tdata[91:83];

    // triangle state
    logic signed [XW-1:0] r_cx [3];
    logic signed [XW-1:0] r_cy [3];
    logic        [DW-1:0] r_cz [3];
    logic        [23:0]   r_color;

    // per-request working registers
    logic [8:0]            r_px, r_py;
    logic                  r_on;
    logic [AW-1:0]         r_idx;
    logic [1:0]            r_k;
    logic signed [EW-1:0]  r_e [3];
    logic signed [RW-1:0]  r_area;
    logic [2:0]            r_cov;
    logic signed [NW-1:0]  r_num;
    logic signed [NW-1:0]  r_n;
    logic [QW-1:0]         r_d;
    logic [NW-1:0]         r_rem;
    logic [NW-1:0]         r_dsh;
    logic [3:0]            r_cnt;
    logic [DW-1:0]         r_q;
    logic                  r_wr;
    logic [7:0]            r_red, r_green, r_blue;
    logic [AW-1:0]         r_clr;

    // output register
    logic                  r_m_valid;
    logic [63:0]           r_m_data;

    logic accept;
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // pixel address of the incoming request
    logic          in_on;
    logic [AW-1:0] in_idx;
    assign in_on  = (int'(in_px) < SCREEN_WIDTH) && (int'(in_py) < SCREEN_HEIGHT);
    assign in_idx = in_on ? AW'((HM1 - AW'(in_py)) * WCONST + AW'(in_px)) : '0;

    // pixel centre in Q12.4
    logic signed [FW-1:0] cen_x, cen_y;
    assign cen_x = $signed({4'b0000, r_px, 4'b1000});
    assign cen_y = $signed({4'b0000, r_py, 4'b1000});

    // edge walk: corners a -> b of edge r_k, and the depth weight
    logic signed [XW-1:0] xa, ya, xb, yb;
    logic signed [EW-1:0] e_sel;
    logic        [DW-1:0] z_sel;
    always_comb begin
        unique case (r_k)
            2'd0: begin
                xa = r_cx[0]; ya = r_cy[0]; xb = r_cx[1]; yb = r_cy[1];
                e_sel = r_e[0]; z_sel = r_cz[2];
            end
            2'd1: begin
                xa = r_cx[1]; ya = r_cy[1]; xb = r_cx[2]; yb = r_cy[2];
                e_sel = r_e[1]; z_sel = r_cz[0];
            end
            default: begin
                xa = r_cx[2]; ya = r_cy[2]; xb = r_cx[0]; yb = r_cy[0];
                e_sel = r_e[2]; z_sel = r_cz[1];
            end
        endcase
    end

    logic signed [FW-1:0]   dx_w, dy_w, rx_w, ry_w;
    logic signed [2*FW-1:0] p1, p2;
    logic signed [EW-1:0]   edge_val;
    assign dx_w = FW'(xb) - FW'(xa);
    assign dy_w = FW'(yb) - FW'(ya);
    assign rx_w = cen_x - FW'(xa);
    assign ry_w = cen_y - FW'(ya);
    assign p1 = dx_w * ry_w;
    assign p2 = dy_w * rx_w;
    assign edge_val = EW'(p1) - EW'(p2);

    // coverage of the four quarter-pixel samples, edges stepped by +-4
    logic [2:0] cov_w;
    always_comb begin
        logic signed [FW-1:0] ddx [3];
        logic signed [FW-1:0] ddy [3];
        logic signed [SW-1:0] s;
        logic                 all_pos, all_neg;
        ddx[0] = FW'(r_cx[1]) - FW'(r_cx[0]); ddy[0] = FW'(r_cy[1]) - FW'(r_cy[0]);
        ddx[1] = FW'(r_cx[2]) - FW'(r_cx[1]); ddy[1] = FW'(r_cy[2]) - FW'(r_cy[1]);
        ddx[2] = FW'(r_cx[0]) - FW'(r_cx[2]); ddy[2] = FW'(r_cy[0]) - FW'(r_cy[2]);
        cov_w = '0;
        for (int i = 0; i < 4; i++) begin
            all_pos = 1'b1;
            all_neg = 1'b1;
            for (int k = 0; k < 3; k++) begin
                s = SW'(r_e[k])
                  + ((i & 2) != 0 ? SW'(ddx[k]) <<< 2 : -(SW'(ddx[k]) <<< 2))
                  - ((i & 1) != 0 ? SW'(ddy[k]) <<< 2 : -(SW'(ddy[k]) <<< 2));
                all_pos = all_pos && (s > 0);
                all_neg = all_neg && (s < 0);
            end
            cov_w = cov_w + 3'(all_pos || all_neg);
        end
    end

    // depth numerator term
    logic signed [EW+DW:0] mterm;
    assign mterm = e_sel * $signed({1'b0, z_sel});

    // sign-normalized quotient operands
    logic signed [NW-1:0] num_s;
    logic signed [RW-1:0] area_abs;
    assign num_s    = (r_area < 0) ? -r_num : r_num;
    assign area_abs = (r_area < 0) ? -r_area : r_area;

    // restoring division step
    logic [NW-1:0] trial;
    logic          trial_ok;
    assign trial_ok = (r_rem >= r_dsh);
    assign trial    = r_rem - r_dsh;

    // depth ram
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata, ram_rdata;
    logic          hit;
    assign hit = (r_q < ram_rdata);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = tpc_pkg::DEPTH_FAR;
        priority if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
        end else if (accept && in_cmd == tpc_pkg::CMD_CLEAR && in_on) begin
            ram_we    = 1'b1;
            ram_waddr = in_idx;
        end else if (r_state == S_DEPTH && hit) begin
            ram_we    = 1'b1;
            ram_wdata = r_q;
        end else begin
            ram_we    = 1'b0;
        end
    end
    assign ram_re = (r_state == S_COV);

    tpc_ram #(
        .DATA_W (DW),
        .DEPTH  (NPIX)
    ) u_depth (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // colour scaled by coverage/4
    logic [10:0] sc_r, sc_g, sc_b;
    assign sc_r = 11'(r_color[23:16]) * 11'(r_cov);
    assign sc_g = 11'(r_color[15:8])  * 11'(r_cov);
    assign sc_b = 11'(r_color[7:0])   * 11'(r_cov);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_m_valid <= 1'b0;
            r_color   <= '0;
            for (int k = 0; k < 3; k++) begin
                r_cx[k] <= '0;
                r_cy[k] <= '0;
                r_cz[k] <= '0;
            end
        end else begin
            // the result stage reloads the slot itself
            if (r_m_valid && i_m_tready && r_state != S_OUT) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_px  <= in_px;
                        r_py  <= in_py;
                        r_on  <= in_on;
                        r_idx <= in_idx;
                        r_k   <= 2'd0;
                        unique case (in_cmd)
                            tpc_pkg::CMD_LOAD: begin
                                unique case (in_slot)
                                    2'd0: begin
                                        r_cx[0] <= in_x; r_cy[0] <= in_y; r_cz[0] <= in_z;
                                        r_color <= in_color;
                                    end
                                    2'd1: begin
                                        r_cx[1] <= in_x; r_cy[1] <= in_y; r_cz[1] <= in_z;
                                    end
                                    2'd2: begin
                                        r_cx[2] <= in_x; r_cy[2] <= in_y; r_cz[2] <= in_z;
                                    end
                                    default: ;
                                endcase
                            end
                            tpc_pkg::CMD_SHADE: r_state <= S_EDGE;
                            default: ;
                        endcase
                    end
                end
                S_EDGE: begin
                    unique case (r_k)
                        2'd0:    r_e[0] <= edge_val;
                        2'd1:    r_e[1] <= edge_val;
                        default: r_e[2] <= edge_val;
                    endcase
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'd2) begin
                        r_state <= S_COV;
                    end
                end
                S_COV: begin
                    r_cov  <= cov_w;
                    r_area <= RW'(r_e[0]) + RW'(r_e[1]) + RW'(r_e[2]);
                    r_num  <= '0;
                    r_k    <= 2'd0;
                    r_wr   <= 1'b0;
                    r_q    <= '0;
                    r_red  <= '0;
                    r_green <= '0;
                    r_blue <= '0;
                    if (cov_w == 3'd0 || !r_on) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_num <= r_num + NW'(mterm);
                    r_k   <= r_k + 1'b1;
                    if (r_k == 2'd2) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_n     <= (num_s <<< 1) + NW'(area_abs);
                    r_d     <= QW'(area_abs) << 1;
                    r_state <= S_DCHK;
                end
                S_DCHK: begin
                    r_rem <= NW'(r_n);
                    r_dsh <= NW'(r_d) << 15;
                    r_cnt <= 4'd15;
                    priority if (r_n < 0) begin
                        r_q     <= '0;
                        r_state <= S_DEPTH;
                    end else if ($unsigned(r_n) >= (NW'(r_d) << 16)) begin
                        r_q     <= tpc_pkg::DEPTH_FAR;
                        r_state <= S_DEPTH;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (trial_ok) begin
                        r_rem <= trial;
                    end
                    r_q   <= {r_q[DW-2:0], trial_ok};
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 4'd0) begin
                        r_state <= S_DEPTH;
                    end
                end
                S_DEPTH: begin
                    r_wr <= hit;
                    if (hit) begin
                        r_red   <= sc_r[9:2];
                        r_green <= sc_g[9:2];
                        r_blue  <= sc_b[9:2];
                    end else begin
                        r_q <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {2'b00, r_blue, r_green, r_red, r_q, r_cov,
                                      tpc_pkg::PIX_IDX_W'(r_idx), r_wr};
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a result is never counted above four samples
    a_cov_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> r_m_data[21:19] <= 3'd4)
        else $error("coverage above four");

    // a written pixel always has coverage
    a_wr_cov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_m_data[0] |-> r_m_data[21:19] != 3'd0)
        else $error("written pixel without coverage");

    // a rejected pixel carries no depth or colour
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && !r_m_data[0] |-> r_m_data[61:22] == '0)
        else $error("rejected pixel with payload");

    // no request is taken, and the ram is written, while the depth sweep runs
    a_sweep_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !accept && ram_we)
        else $error("request during depth sweep");

endmodule
`default_nettype wire
